FILE: hw/rtl/md5_pkg.sv
`timescale 1ns / 1ps
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hEFCDAB89;
  localparam logic [31:0] InitC = 32'h98BADCFE;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;

  localparam logic [31:0] StepConst [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  // message word index used by step i
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] j;
    j = i[3:0];
    case (i[5:4])
      2'd0:    msg_index = j;
      2'd1:    msg_index = 4'((5 * j) + 1);
      2'd2:    msg_index = 4'((3 * j) + 5);
      default: msg_index = 4'(7 * j);
    endcase
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'h0: r = 5'd7;  4'h1: r = 5'd12; 4'h2: r = 5'd17; 4'h3: r = 5'd22;
      4'h4: r = 5'd5;  4'h5: r = 5'd9;  4'h6: r = 5'd14; 4'h7: r = 5'd20;
      4'h8: r = 5'd4;  4'h9: r = 5'd11; 4'hA: r = 5'd16; 4'hB: r = 5'd23;
      4'hC: r = 5'd6;  4'hD: r = 5'd10; 4'hE: r = 5'd15; default: r = 5'd21;
    endcase
    rot_amount = r;
  endfunction

endpackage

FILE: hw/rtl/md5_ram.sv
`timescale 1ns / 1ps
module md5_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: hw/rtl/md5_round.sv
`timescale 1ns / 1ps
module md5_round (
  input  logic [5:0]  step_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  input  logic [31:0] m_i,
  output logic [31:0] b_o
);
  import md5_pkg::*;
  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  s;

  // round function, then rotate and add
  always_comb begin
    case (step_i[5:4])
      2'd0:    f = (b_i & c_i) | (~b_i & d_i);
      2'd1:    f = (b_i & d_i) | (c_i & ~d_i);
      2'd2:    f = b_i ^ c_i ^ d_i;
      default: f = c_i ^ (b_i | ~d_i);
    endcase
    sum = a_i + f + StepConst[step_i] + m_i;
    s   = rot_amount(step_i);
    b_o = b_i + ((sum << s) | (sum >> (6'd32 - {1'b0, s})));
  end
endmodule

FILE: hw/rtl/md5_stream_hasher.sv
`timescale 1ns / 1ps
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | md5_in_t  (byte, has_byte, end)
// out     | out | out_valid/out_ready| md5_out_t (word, index, last)
// Byte beats are taken only while idle; the 64th byte of a block starts a
// compression: one MD5 step per cycle from the block RAM, then chain add.
// An end beat pads byte by byte (up to 72 pad bytes, two compressions), then
// emits four digest beats; input stalls until the last one is taken.
// Reset is asynchronous; block RAM holds no reset and needs no clearing.
module md5_stream_hasher (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_ready,
  input  md5_pkg::md5_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output md5_pkg::md5_out_t out_data
);
  import md5_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StComp = 3'd2;
  localparam logic [2:0] StAdd  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [63:0] cnt_q, cnt_d;
  logic [63:0] bits_q, bits_d;
  logic        fin_q, fin_d;
  logic        mark_q, mark_d;
  logic        len_q, len_d;
  logic [6:0]  step_q, step_d;
  logic [1:0]  oidx_q, oidx_d;
  logic [31:0] ch_q [4];
  logic [31:0] ch_d [4];
  logic [31:0] a_q, b_q, c_q, d_q, a_d, b_d, c_d, d_d;
  logic [31:0] cur_q, cur_d;

  logic        push;
  logic [7:0]  pbyte;
  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata, newb;

  md5_ram #(.Width(32), .Depth(16)) u_blk (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  md5_round u_round (
    .step_i(step_q[5:0]), .a_i(a_q), .b_i(b_q), .c_i(c_q), .d_i(d_q),
    .m_i(rdata), .b_o(newb)
  );

  // word being assembled is held in cur_q; written to RAM every byte
  assign waddr = cnt_q[5:2];
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    wdata = {24'd0, pbyte};
      2'd1:    wdata = {16'd0, pbyte, cur_q[7:0]};
      2'd2:    wdata = {8'd0, pbyte, cur_q[15:0]};
      default: wdata = {pbyte, cur_q[23:0]};
    endcase
  end
  assign we = push;

  // read address runs one step ahead of the round logic
  assign raddr = (state_q == StComp) ? msg_index(6'(step_q + 7'd1)) : msg_index(6'd0);

  assign in_ready  = (state_q == StIdle);
  assign out_valid = (state_q == StOut);
  assign out_data.digest_word = ch_q[oidx_q];
  assign out_data.word_index  = oidx_q;
  assign out_data.last_word   = (oidx_q == 2'd3);

  // byte source during padding: marker, zeros, then length in the last block
  always_comb begin
    pbyte = in_data.data_byte;
    if (state_q == StPad) begin
      if (mark_q) pbyte = PadByte;
      else if (len_q && cnt_q[5:0] >= 6'd56) pbyte = bits_q[(cnt_q[2:0]*8) +: 8];
      else pbyte = 8'd0;
    end
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; bits_d = bits_q; fin_d = fin_q;
    mark_d = mark_q; len_d = len_q;
    step_d = step_q; oidx_d = oidx_q; ch_d = ch_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; cur_d = cur_q;
    push = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid) begin
          push = in_data.has_byte;
          if (in_data.end_of_message) begin
            bits_d = (in_data.has_byte ? cnt_q + 64'd1 : cnt_q) << 3;
            fin_d  = 1'b1;
            mark_d = 1'b1;
            len_d  = 1'b0;
          end
        end
      end
      StPad: begin
        push = 1'b1;
        if (mark_q) begin
          mark_d = 1'b0;
          // length still fits behind the marker in this block
          if (cnt_q[5:0] < 6'd56) len_d = 1'b1;
        end
      end
      StComp: begin
        a_d = d_q; d_d = c_q; c_d = b_q; b_d = newb;
        step_d = step_q + 7'd1;
        if (step_q == 7'd63) state_d = StAdd;
      end
      StAdd: begin
        ch_d[0] = ch_q[0] + a_q; ch_d[1] = ch_q[1] + b_q;
        ch_d[2] = ch_q[2] + c_q; ch_d[3] = ch_q[3] + d_q;
        if (!fin_q) begin
          state_d = StIdle;
        end else if (len_q) begin
          state_d = StOut;
        end else begin
          state_d = StPad;
          // marker already placed: the next block carries the length
          if (!mark_q) len_d = 1'b1;
        end
      end
      StOut: begin
        if (out_ready) begin
          oidx_d = oidx_q + 2'd1;
          if (oidx_q == 2'd3) begin
            state_d = StIdle; cnt_d = '0; fin_d = 1'b0; len_d = 1'b0;
            ch_d[0] = InitA; ch_d[1] = InitB; ch_d[2] = InitC; ch_d[3] = InitD;
          end
        end
      end
      default: state_d = StIdle;
    endcase
    if (state_q == StIdle && in_valid && in_data.end_of_message) begin
      // first pad byte follows (after any compression of the last data byte)
      state_d = StPad;
    end
    if (push) begin
      cur_d = wdata;
      cnt_d = cnt_q + 64'd1;
      if (cnt_q[5:0] == 6'd63) begin
        state_d = StComp; step_d = '0;
        a_d = ch_q[0]; b_d = ch_q[1]; c_d = ch_q[2]; d_d = ch_q[3];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= '0; fin_q <= 1'b0; step_q <= '0; oidx_q <= '0;
      mark_q <= 1'b0; len_q <= 1'b0;
      ch_q[0] <= InitA; ch_q[1] <= InitB; ch_q[2] <= InitC; ch_q[3] <= InitD;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; fin_q <= fin_d; step_q <= step_d;
      mark_q <= mark_d; len_q <= len_d;
      oidx_q <= oidx_d; ch_q <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d; cur_q <= cur_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
  end
endmodule

FILE: hw/rtl/md5_checker.sv
`timescale 1ns / 1ps
module md5_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input md5_pkg::md5_out_t out_data
);
  // no input taken while a digest is being shown
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input open during digest");
  // last flag only on word three
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_data.last_word == (out_data.word_index == 2'd3)))
    else $error("last flag mismatch");
  // words advance in order
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_data.last_word |=>
      out_valid && out_data.word_index == $past(out_data.word_index) + 2'd1)
    else $error("digest order");
  // stalled output holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
endmodule

bind md5_stream_hasher md5_checker u_md5_checker (
  .clk_i, .rst_ni, .in_ready, .out_valid, .out_ready, .out_data
);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import md5_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  md5_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  md5_out_t out_data;

  md5_stream_hasher dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [31:0] hash_chain [4];
  logic [63:0] msg_bytes;
  logic [31:0] msg_block [16];
  md5_out_t    digest_q [$];

  int errors = 0;
  int beats_sent = 0;
  int digests_seen = 0;
  int words_seen = 0;
  int stall_left = 0;
  longint cycles = 0;
  bit quiet_send = 1'b0;

  function automatic logic [31:0] rotl(logic [31:0] x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  // 64-step compression with its own shift table and message order
  function automatic void md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int rnd, j, g, s;
    int shifts [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
    for (int i = 0; i < 64; i++) begin
      rnd = i / 16;
      j = i % 16;
      case (rnd)
        0: begin f = (b & c) | (~b & d); g = j; end
        1: begin f = (b & d) | (c & ~d); g = (5 * j + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * j + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * j) % 16; end
      endcase
      s = shifts[rnd * 4 + (i % 4)];
      t = d; d = c; c = b;
      b = b + rotl(a + f + StepConst[i] + msg_block[g], s);
      a = t;
    end
    hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
  endfunction

  function automatic void hasher_clear();
    hash_chain = '{InitA, InitB, InitC, InitD};
    msg_bytes = '0;
    foreach (msg_block[k]) msg_block[k] = '0;
  endfunction

  function automatic void absorb_byte(logic [7:0] v);
    int pos;
    pos = int'(msg_bytes[5:0]);
    if (pos % 4 == 0) msg_block[pos / 4] = '0;
    msg_block[pos / 4][8 * (pos % 4) +: 8] = v;
    msg_bytes++;
    if (msg_bytes[5:0] == 6'd0) md5_compress();
  endfunction

  // update the model on one accepted beat, queue digest words at message end
  function automatic void predict_beat(md5_in_t beat);
    logic [63:0] bit_len;
    md5_out_t w;
    if (beat.has_byte) absorb_byte(beat.data_byte);
    if (!beat.end_of_message) return;
    bit_len = msg_bytes << 3;
    absorb_byte(PadByte);
    while (msg_bytes[5:0] != 6'd56) absorb_byte(8'h00);
    for (int k = 0; k < 8; k++) absorb_byte(bit_len[8 * k +: 8]);
    for (int k = 0; k < 4; k++) begin
      w.digest_word = hash_chain[k];
      w.word_index = 2'(k);
      w.last_word = (k == 3);
      digest_q.push_back(w);
    end
    hasher_clear();
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (digest %0d)", what, got, want, digests_seen);
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // send one beat; valid drops only when a gap goes before it
  task automatic send_beat(logic [7:0] v, bit has, bit eom);
    md5_in_t beat;
    int gap;
    beat.data_byte = v; beat.has_byte = has; beat.end_of_message = eom;
    gap = quiet_send ? 0 : rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk_i); while (!in_ready);
    predict_beat(beat);
    beats_sent++;
  endtask

  task automatic send_message(int len, bit last_has);
    for (int i = 0; i < len; i++) send_beat(8'($urandom), 1'b1, 1'b0);
    send_beat(8'($urandom), last_has, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // directed: empty message, one byte with end, extremes, empty items
  task automatic test_directed();
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h61, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hAA, 1'b0, 1'b0);
    send_beat(8'h55, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b0, 1'b1);
  endtask

  // padding boundaries: 56 bytes (extra length block), 64 bytes (block ends on end)
  task automatic test_pad_edges();
    send_message(55, 1'b1);
    send_message(63, 1'b1);
  endtask

  // random short messages with empty items sprinkled in
  task automatic test_random();
    int len;
    while (beats_sent < 160) begin
      len = $urandom_range(0, 20);
      quiet_send = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++)
        send_beat(8'($urandom), ($urandom_range(0, 9) != 0), 1'b0);
      send_beat(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
    end
    quiet_send = 1'b0;
  endtask

  // result checker and random back-pressure
  always @(posedge clk_i) begin
    md5_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        report("unexpected beat", out_data.digest_word, '0);
      end else begin
        want = digest_q.pop_front();
        if (out_data.digest_word !== want.digest_word)
          report("digest_word", out_data.digest_word, want.digest_word);
        if (out_data.word_index !== want.word_index)
          report("word_index", 32'(out_data.word_index), 32'(want.word_index));
        if (out_data.last_word !== want.last_word)
          report("last_word", 32'(out_data.last_word), 32'(want.last_word));
        words_seen++;
        if (want.last_word) digests_seen++;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = quiet_send ? 0 : rand_gap();
      out_ready <= (stall_left == 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    hasher_clear();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pad_edges();
    test_random();
    wait_drained();
    $display("covered %0d input beats, %0d digests (%0d words)",
             beats_sent, digests_seen, words_seen);
    $display("messages up to 64 bytes, padding edges, empty items and random stalls");
    if (errors == 0 && digest_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
